// ===== rtl/core/rolling_spearman_rank_correlation_assert.svh =====
// assertion macros for the rolling spearman rank correlation block
// no dependencies; taken in by the modules that carry assertions
`ifndef ROLLING_SPEARMAN_RANK_CORRELATION_ASSERT_SVH
`define ROLLING_SPEARMAN_RANK_CORRELATION_ASSERT_SVH

// same-cycle implication, off during reset
`define RSRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define RSRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/rsrc_pkg.sv =====
// shared constants and types of the rolling spearman rank correlation block
// no dependencies; used by the interfaces, the divider and the top level
package rsrc_pkg;

   // window store
   localparam int WIN_MAX = 64;
   localparam int SMP_W   = 32;
   localparam int WIN_W   = 7;
   localparam int MIN_LEN = 4;
   localparam int IDX_W   = $clog2(WIN_MAX);
   localparam int CNT_W   = $clog2(WIN_MAX + 1);
   localparam int WC_W    = (WIN_W > CNT_W) ? WIN_W : CNT_W;

   // arithmetic widths
   localparam int PROD_W  = 3 * CNT_W + 2;
   localparam int D_W     = 3 * CNT_W;
   localparam int S_W     = 3 * CNT_W;
   localparam int SHIFT_D = 15;
   localparam int SHIFT_S = 16;
   localparam int NUM_W   = S_W + SHIFT_S + 3;
   localparam int DVD_W   = NUM_W + 1;
   localparam int DVS_W   = D_W + 1;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // result format
   localparam int RHO_W = 16;
   localparam logic [RHO_W-1:0] RHO_MAX = 16'h7FFF;
   localparam logic [RHO_W-1:0] RHO_MIN = 16'h8000;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_result_type;

endpackage

// ===== rtl/core/rsrc_req_if.sv =====
// request channel: one sample pair per beat
// depends on rsrc_pkg
interface rsrc_req_if import rsrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SMP_W-1:0] signal_sample;
   logic [SMP_W-1:0] return_sample;
   logic             last_of_series;

   modport source (output valid, signal_sample, return_sample, last_of_series,
                   input ready);
   modport sink   (input valid, signal_sample, return_sample, last_of_series,
                   output ready);
endinterface

// ===== rtl/core/rsrc_rsp_if.sv =====
// response channel: one correlation result per beat
// depends on rsrc_pkg
interface rsrc_rsp_if import rsrc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [RHO_W-1:0] rank_correlation;
   logic                    correlation_valid;

   modport source (output valid, rank_correlation, correlation_valid, input ready);
   modport sink   (input valid, rank_correlation, correlation_valid, output ready);
endinterface

// ===== rtl/core/rsrc_csr_if.sv =====
// configuration write channel for the window length register
// depends on rsrc_pkg
interface rsrc_csr_if import rsrc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [WIN_W-1:0] window_length;

   modport source (output valid, window_length, input ready);
   modport sink   (input valid, window_length, output ready);
endinterface

// ===== rtl/core/rsrc_divider.sv =====
// restoring serial divider, one quotient bit per cycle
// depends on rsrc_pkg
module rsrc_divider import rsrc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output div_result_type   div_res
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W:0]       trial;
   logic [DVS_W:0]       trial_sub;
   logic                 fits;

   always_comb begin
      trial     = {rem_ff, quo_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      fits      = trial >= {1'b0, dvs_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_res.done     = done_ff;
   assign div_res.quotient = quo_ff;

endmodule

// ===== rtl/core/rolling_spearman_rank_correlation.sv =====
// top level of the rolling spearman rank correlation block
// depends on rsrc_pkg, the channel interfaces, rsrc_divider and the assertion header
//
// usage
//   req_chan carries one (signal, return) pair per beat, plus a last-of-series flag.
//   rsp_chan returns one beat per request: a q1.15 rank correlation over the last
//   L = min(pairs seen, window) pairs and a valid flag that is set when L >= 4.
//   csr_chan writes the window length, always ready; values clamp to 4 .. 64 on use.
//   the user must write it only while no request is in flight; not enforced.
// timing
//   req_chan is ready only in the idle state, so one pair is worked on at a time.
//   with L >= 4 one shared comparator pair sweeps the window once per sample,
//   its pace set by the single read port of each ring, then a serial divider forms
//   the quotient. with L < 4 setup sends a zero result straight to the done state.
// reset and stall
//   reset empties the history and sets the window to 64; ring contents are not
//   cleared, only entries written since the last clear are read. a finished result
//   sits in an output register, so the next pair is taken while it waits; a second
//   result waits in the done state until the output register is free.
module rolling_spearman_rank_correlation import rsrc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rsrc_req_if.sink   req_chan,
   rsrc_rsp_if.source rsp_chan,
   rsrc_csr_if.sink   csr_chan
);

`include "rolling_spearman_rank_correlation_assert.svh"

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_SETUP = 13'b0000000000010,
      ST_VCAP  = 13'b0000000000100,
      ST_SCAN  = 13'b0000000001000,
      ST_SQR   = 13'b0000000010000,
      ST_LSQ   = 13'b0000000100000,
      ST_DEN   = 13'b0000001000000,
      ST_NUM3S = 13'b0000010000000,
      ST_NUM   = 13'b0000100000000,
      ST_ABS   = 13'b0001000000000,
      ST_DVD   = 13'b0010000000000,
      ST_DIV   = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   // ring pointer step with wrap at the end of the store
   function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(WIN_MAX - 1)) ? '0 : p + 1'b1;
   endfunction

   // window stores, raw samples; signed compare gives the key order
   logic [SMP_W-1:0] sig_ring [WIN_MAX];
   logic [SMP_W-1:0] ret_ring [WIN_MAX];
   logic [SMP_W-1:0] sig_rd_ff, ret_rd_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             ring_we;

   // control state
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0] pairs_ff, pairs_in;
   logic [WIN_W-1:0] win_ff, win_in;
   logic             last_ff, last_in;
   logic             acc_pend_ff, acc_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // sweep state
   logic [CNT_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0] len_m1;
   logic [IDX_W-1:0] first_ff, first_in;
   logic [IDX_W-1:0] k_idx_ff, k_idx_in;
   logic [IDX_W-1:0] j_idx_ff, j_idx_in;
   logic [IDX_W-1:0] j_ptr_ff, j_ptr_in;
   logic [SMP_W-1:0] v_sig_ff, v_sig_in, v_ret_ff, v_ret_in;
   logic [SMP_W-1:0] nv_sig_ff, nv_sig_in, nv_ret_ff, nv_ret_in;
   logic [IDX_W-1:0] rank_sig_ff, rank_sig_in, rank_ret_ff, rank_ret_in;

   // arithmetic state
   logic signed [CNT_W:0]    mul_a;
   logic signed [2*CNT_W:0]  mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [S_W-1:0]           acc_ff, acc_in;
   logic [D_W-1:0]           d_ff, d_in;
   logic [S_W+1:0]           s3_ff, s3_in;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]         mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [RHO_W-1:0]         res_rho_ff, res_rho_in;
   logic                     res_cval_ff, res_cval_in;
   logic [RHO_W-1:0]         out_rho_ff, out_rho_in;
   logic                     out_cval_ff, out_cval_in;

   // divider hookup
   logic             div_start;
   logic [DVD_W-1:0] div_dividend;
   logic [DVS_W-1:0] div_divisor;
   div_result_type   div_res;

   // helpers
   logic [WC_W-1:0]  win_x;
   logic [CNT_W-1:0] win_eff;
   logic [CNT_W-1:0] len_new;
   logic [CNT_W:0]   wp_x, len_x, first_x;
   logic             sig_lt, sig_eq, ret_lt, ret_eq, earlier;
   logic signed [CNT_W:0] diff;
   logic [2*CNT_W-1:0] lsq_m1;
   logic [DVD_W-1:0] q;
   logic             req_acc;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign len_m1  = IDX_W'(len_ff - 1'b1);

   rsrc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .div_res   (div_res)
   );

   // the one small multiplier, shared by squares and the denominator
   assign mul_p = mul_a * mul_b;

   always_comb begin
      // defaults: hold
      state_in     = state_ff;
      wp_in        = wp_ff;
      pairs_in     = pairs_ff;
      win_in       = win_ff;
      last_in      = last_ff;
      acc_pend_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      len_in       = len_ff;
      first_in     = first_ff;
      k_idx_in     = k_idx_ff;
      j_idx_in     = j_idx_ff;
      j_ptr_in     = j_ptr_ff;
      v_sig_in     = v_sig_ff;
      v_ret_in     = v_ret_ff;
      nv_sig_in    = nv_sig_ff;
      nv_ret_in    = nv_ret_ff;
      rank_sig_in  = rank_sig_ff;
      rank_ret_in  = rank_ret_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      s3_in        = s3_ff;
      num_in       = num_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      res_rho_in   = res_rho_ff;
      res_cval_in  = res_cval_ff;
      out_rho_in   = out_rho_ff;
      out_cval_in  = out_cval_ff;
      ring_we      = 1'b0;
      rd_addr      = j_ptr_ff;
      div_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;

      // window clamp and length of the current window
      win_x = WC_W'(win_ff);
      if (win_x < WC_W'(MIN_LEN)) begin
         win_eff = CNT_W'(MIN_LEN);
      end else if (win_x > WC_W'(WIN_MAX)) begin
         win_eff = CNT_W'(WIN_MAX);
      end else begin
         win_eff = CNT_W'(win_ff);
      end
      len_new = (pairs_ff < win_eff) ? pairs_ff : win_eff;
      wp_x    = {1'b0, wp_ff};
      len_x   = {1'b0, len_new};
      first_x = (wp_x >= len_x) ? (wp_x - len_x) : (wp_x + (CNT_W+1)'(WIN_MAX) - len_x);

      // comparator pair: streamed entry against the sample being ranked
      sig_lt  = $signed(sig_rd_ff) < $signed(v_sig_ff);
      sig_eq  = sig_rd_ff == v_sig_ff;
      ret_lt  = $signed(ret_rd_ff) < $signed(v_ret_ff);
      ret_eq  = ret_rd_ff == v_ret_ff;
      earlier = j_idx_ff < k_idx_ff;

      diff   = $signed({1'b0, CNT_W'(rank_sig_ff)}) - $signed({1'b0, CNT_W'(rank_ret_ff)});
      lsq_m1 = prod_ff[2*CNT_W-1:0] - 1'b1;
      q      = div_res.quotient;

      div_dividend = {mag_ff, 1'b0} + DVD_W'(d_ff);
      div_divisor  = {d_ff, 1'b0};

      // square of the previous sample is added to the sum the cycle after it is registered
      if (acc_pend_ff) begin
         acc_in = acc_ff + S_W'(prod_ff);
      end

      // config write
      if (csr_chan.valid) begin
         win_in = csr_chan.window_length;
      end

      // output register drains on a taken beat
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ring_we  = 1'b1;
               wp_in    = ptr_inc(wp_ff);
               pairs_in = (pairs_ff < CNT_W'(WIN_MAX)) ? pairs_ff + 1'b1 : pairs_ff;
               last_in  = req_chan.last_of_series;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            len_in   = len_new;
            first_in = first_x[IDX_W-1:0];
            rd_addr  = first_x[IDX_W-1:0];
            k_idx_in = '0;
            acc_in   = '0;
            if (last_ff) begin
               // end of series: history cleared here; this result still covers the current window
               pairs_in = '0;
               wp_in    = '0;
            end
            if (len_new < CNT_W'(MIN_LEN)) begin
               res_rho_in  = '0;
               res_cval_in = 1'b0;
               state_in    = ST_DONE;
            end else begin
               state_in = ST_VCAP;
            end
         end
         ST_VCAP: begin
            // oldest sample becomes the first one ranked
            v_sig_in    = sig_rd_ff;
            v_ret_in    = ret_rd_ff;
            rd_addr     = first_ff;
            j_ptr_in    = ptr_inc(first_ff);
            j_idx_in    = '0;
            rank_sig_in = '0;
            rank_ret_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            rd_addr  = j_ptr_ff;
            j_ptr_in = ptr_inc(j_ptr_ff);
            j_idx_in = j_idx_ff + 1'b1;
            // ties broken oldest first
            rank_sig_in = rank_sig_ff + IDX_W'(sig_lt || (sig_eq && earlier));
            rank_ret_in = rank_ret_ff + IDX_W'(ret_lt || (ret_eq && earlier));
            // next sample to rank streams past during this sweep
            if ({1'b0, j_idx_ff} == {1'b0, k_idx_ff} + 1'b1) begin
               nv_sig_in = sig_rd_ff;
               nv_ret_in = ret_rd_ff;
            end
            if (j_idx_ff == len_m1) begin
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            mul_a       = diff;
            mul_b       = {{CNT_W{diff[CNT_W]}}, diff};
            prod_in     = PROD_W'(mul_p);
            acc_pend_in = 1'b1;
            if (k_idx_ff == len_m1) begin
               state_in = ST_LSQ;
            end else begin
               k_idx_in    = k_idx_ff + 1'b1;
               v_sig_in    = nv_sig_ff;
               v_ret_in    = nv_ret_ff;
               rd_addr     = first_ff;
               j_ptr_in    = ptr_inc(first_ff);
               j_idx_in    = '0;
               rank_sig_in = '0;
               rank_ret_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_LSQ: begin
            mul_a    = $signed({1'b0, len_ff});
            mul_b    = $signed((2*CNT_W+1)'(len_ff));
            prod_in  = PROD_W'(mul_p);
            state_in = ST_DEN;
         end
         ST_DEN: begin
            // d = L * (L^2 - 1)
            mul_a    = $signed({1'b0, len_ff});
            mul_b    = $signed({1'b0, lsq_m1});
            prod_in  = PROD_W'(mul_p);
            state_in = ST_NUM3S;
         end
         ST_NUM3S: begin
            d_in     = prod_ff[D_W-1:0];
            s3_in    = {2'b00, acc_ff} + {1'b0, acc_ff, 1'b0};
            state_in = ST_NUM;
         end
         ST_NUM: begin
            // num = 32768*d - 196608*sum(d^2)
            num_in   = $signed(NUM_W'({d_ff, {SHIFT_D{1'b0}}}))
                     - $signed(NUM_W'({s3_ff, {SHIFT_S{1'b0}}}));
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = num_ff[NUM_W-1];
            mag_in   = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
            state_in = ST_DVD;
         end
         ST_DVD: begin
            // round half away: (2|num| + d) / 2d
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_res.done) begin
               res_cval_in = 1'b1;
               if (!neg_ff) begin
                  res_rho_in = (q > DVD_W'(RHO_MAX)) ? RHO_MAX : q[RHO_W-1:0];
               end else begin
                  res_rho_in = (q > DVD_W'(RHO_MIN)) ? RHO_MIN : RHO_W'(-q[RHO_W-1:0]);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_rho_in   = res_rho_ff;
               out_cval_in  = res_cval_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ring write and registered read
   always_ff @(posedge clock) begin
      if (ring_we) begin
         sig_ring[wp_ff] <= req_chan.signal_sample;
         ret_ring[wp_ff] <= req_chan.return_sample;
      end
      sig_rd_ff <= sig_ring[rd_addr];
      ret_rd_ff <= ret_ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         pairs_ff     <= '0;
         win_ff       <= WIN_W'(WIN_MAX);
         acc_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         pairs_ff     <= pairs_in;
         win_ff       <= win_in;
         acc_pend_ff  <= acc_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      len_ff      <= len_in;
      first_ff    <= first_in;
      k_idx_ff    <= k_idx_in;
      j_idx_ff    <= j_idx_in;
      j_ptr_ff    <= j_ptr_in;
      v_sig_ff    <= v_sig_in;
      v_ret_ff    <= v_ret_in;
      nv_sig_ff   <= nv_sig_in;
      nv_ret_ff   <= nv_ret_in;
      rank_sig_ff <= rank_sig_in;
      rank_ret_ff <= rank_ret_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      s3_ff       <= s3_in;
      num_ff      <= num_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      res_rho_ff  <= res_rho_in;
      res_cval_ff <= res_cval_in;
      out_rho_ff  <= out_rho_in;
      out_cval_ff <= out_cval_in;
   end

   // channel outputs
   assign req_chan.ready             = (state_ff == ST_IDLE);
   assign csr_chan.ready             = 1'b1;
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.rank_correlation  = out_rho_ff;
   assign rsp_chan.correlation_valid = out_cval_ff;

   // checks
   `RSRC_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while a pair is still in work")
   `RSRC_ASSERT_NOW(a_rank_bound, clock, reset, state_ff == ST_SCAN, (rank_sig_ff <= j_idx_ff) && (rank_ret_ff <= j_idx_ff), "rank count ran ahead of the sweep")
   `RSRC_ASSERT_NOW(a_invalid_is_zero, clock, reset, rsp_chan.valid && !rsp_chan.correlation_valid, rsp_chan.rank_correlation == '0, "short window result is not zero")
   `RSRC_ASSERT_NOW(a_pairs_bound, clock, reset, 1'b1, pairs_ff <= CNT_W'(WIN_MAX), "pair count beyond store depth")
   `RSRC_ASSERT_NEXT(a_done_waits, clock, reset, (state_ff == ST_DONE) && rsp_valid_ff && !rsp_chan.ready, state_ff == ST_DONE, "result overwrote a beat still waiting")

endmodule

// ===== test/rolling_spearman_rank_correlation_test.sv =====
// self-checking bench for the rolling spearman rank correlation block
// depends on rsrc_pkg, the three channel interfaces and the block itself
// a directed stimulus table, then random series under several window and flow-control settings
module rolling_spearman_rank_correlation_test import rsrc_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no beat on any channel before the run is called dead
   // it must cover the slowest pair, at a full window, plus stalls
   localparam int STALL_LIMIT = 20000;
   // quiet cycles after the last result, to catch stray beats
   localparam int TAIL_CYCLES = 100;
   localparam int NUM_PHASES = 6;
   // marks a phase whose window is drawn at random
   localparam int RANDOM_WINDOW = -1;

   typedef struct packed {
      logic signed [RHO_W-1:0] rho;
      logic                    ok;
   } corr_type;

   typedef struct packed {
      logic [SMP_W-1:0]        sig;
      logic [SMP_W-1:0]        ret;
      logic                    last;
      logic                    typed;
      logic signed [RHO_W-1:0] rho;
      logic                    ok;
   } stim_row_type;

   localparam logic [SMP_W-1:0] S_MIN = 32'h8000_0000;
   localparam logic [SMP_W-1:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [SMP_W-1:0] S_NEG1 = 32'hFFFF_FFFF;
   localparam logic [RHO_W-1:0] RHO_ZERO = '0;

   // directed rows, run with the window at its reset value of 64
   // where typed is set the expected beat is taken from the row itself
   localparam stim_row_type DIRECTED_ROWS [22] = '{
      // rising in step: short window first, then perfect agreement
      '{32'd1, 32'd1, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd2, 32'd2, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd3, 32'd3, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd4, 32'd4, 1'b0, 1'b1, RHO_MAX, 1'b1},
      // end of series on a valid result
      '{32'd5, 32'd5, 1'b1, 1'b1, RHO_MAX, 1'b1},
      // extremes in opposite order: exactly -1.0
      '{S_MIN, S_MAX, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{S_NEG1, 32'd0, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd0, S_NEG1, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{S_MAX, S_MIN, 1'b1, 1'b1, RHO_MIN, 1'b1},
      // all values tied: ranks fall back to age on both sides
      '{32'd7, 32'd7, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd7, 32'd7, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd7, 32'd7, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd7, 32'd7, 1'b0, 1'b1, RHO_MAX, 1'b1},
      // ties on one side only, then alternating bit patterns
      '{32'd7, 32'hFFFF_FFFB, 1'b0, 1'b0, RHO_ZERO, 1'b0},
      '{S_MAX, S_MIN, 1'b0, 1'b0, RHO_ZERO, 1'b0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, RHO_ZERO, 1'b0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, RHO_ZERO, 1'b0},
      '{32'd0, 32'd0, 1'b1, 1'b0, RHO_ZERO, 1'b0},
      // end of series while the window is still short
      '{S_NEG1, 32'd1, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{32'd1, S_NEG1, 1'b0, 1'b1, RHO_ZERO, 1'b0},
      '{S_MIN, S_MIN, 1'b1, 1'b1, RHO_ZERO, 1'b0},
      '{32'd5, 32'd5, 1'b0, 1'b1, RHO_ZERO, 1'b0}
   };

   // random phases: window written before the phase, item count, flow control
   // and the chance in a hundred that a pair closes its series
   // below 4, zero and above 64 check the clamping; 127 with no series ends
   // fills the history past its depth so the ring wraps and the count saturates
   localparam int PHASE_WINDOW     [NUM_PHASES] = '{4, 0, 3, 127, 65, RANDOM_WINDOW};
   localparam int PHASE_ITEMS      [NUM_PHASES] = '{14, 12, 8, 70, 6, 8};
   localparam int PHASE_SEND_IDLE  [NUM_PHASES] = '{0, 67, 0, 26, 0, 67};
   localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 67, 26, 0, 0};
   localparam int PHASE_LAST_PCT   [NUM_PHASES] = '{10, 15, 10, 0, 0, 20};

   logic clock;
   logic reset;

   rsrc_req_if req_bus ();
   rsrc_rsp_if rsp_bus ();
   rsrc_csr_if csr_bus ();

   rolling_spearman_rank_correlation dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow of the block's history, kept as order keys (sign bit flipped)
   logic [SMP_W-1:0] sig_keys [WIN_MAX];
   logic [SMP_W-1:0] ret_keys [WIN_MAX];
   int unsigned      fill_pos;
   int unsigned      pairs_held;
   logic [WIN_W-1:0] window_reg;

   corr_type pending_corr [$];
   int       mismatch_count = 0;
   int       idle_cycles;
   int       send_idle_pct;
   int       recv_stall_pct;

   // free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // takes one pair into the shadow history and works out the beat it should give
   function automatic corr_type step_correlation(input logic [SMP_W-1:0] sig,
                                                 input logic [SMP_W-1:0] ret,
                                                 input logic last);
      corr_type    res;
      int unsigned win;
      int unsigned span;
      int unsigned oldest;
      int unsigned pos_k;
      int unsigned pos_j;
      longint      rank_sig;
      longint      rank_ret;
      longint      sq_sum;
      longint      diff;
      longint      dd;
      longint      num;
      longint      q;
      logic [SMP_W-1:0] flip;

      flip = {1'b1, {(SMP_W-1){1'b0}}};
      // clamp the register into the legal window range
      win = window_reg;
      if (win < MIN_LEN)
         win = MIN_LEN;
      if (win > WIN_MAX)
         win = WIN_MAX;

      sig_keys[fill_pos] = sig ^ flip;
      ret_keys[fill_pos] = ret ^ flip;
      fill_pos = (fill_pos + 1) % WIN_MAX;
      if (pairs_held < WIN_MAX)
         pairs_held++;

      span = (pairs_held < win) ? pairs_held : win;
      res.rho = '0;
      res.ok = 1'b0;
      if (span >= MIN_LEN) begin
         oldest = (fill_pos + WIN_MAX - span) % WIN_MAX;
         sq_sum = 0;
         for (int unsigned k = 0; k < span; k++) begin
            pos_k = (oldest + k) % WIN_MAX;
            rank_sig = 0;
            rank_ret = 0;
            // rank = count of smaller values, equal values ranked oldest first
            for (int unsigned j = 0; j < span; j++) begin
               pos_j = (oldest + j) % WIN_MAX;
               if (sig_keys[pos_j] < sig_keys[pos_k] ||
                   (sig_keys[pos_j] == sig_keys[pos_k] && j < k))
                  rank_sig++;
               if (ret_keys[pos_j] < ret_keys[pos_k] ||
                   (ret_keys[pos_j] == ret_keys[pos_k] && j < k))
                  rank_ret++;
            end
            diff = rank_sig - rank_ret;
            sq_sum += diff * diff;
         end
         // 1 - 6*sum/(L(L^2-1)) scaled by 2^15, halves rounded away from zero
         dd = longint'(span) * (longint'(span) * longint'(span) - 1);
         num = 32768 * dd - 196608 * sq_sum;
         if (num >= 0)
            q = (2 * num + dd) / (2 * dd);
         else
            q = -((-2 * num + dd) / (2 * dd));
         if (q > 32767)
            q = 32767;
         if (q < -32768)
            q = -32768;
         res.rho = q[RHO_W-1:0];
         res.ok = 1'b1;
      end

      // the result still covers this pair; the history empties afterwards
      if (last) begin
         fill_pos = 0;
         pairs_held = 0;
      end
      return res;
   endfunction

   // random sample: mostly full range, some from a tiny pool for ties, some extremes
   function automatic logic [SMP_W-1:0] draw_sample();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5)
         return $urandom;
      else if (pick < 8)
         return SMP_W'($signed($urandom_range(0, 6)) - 3);
      else begin
         case ($urandom_range(0, 3))
            0: return S_MIN;
            1: return S_MAX;
            2: return '0;
            default: return S_NEG1;
         endcase
      end
   endfunction

   // offers one pair beat, with random idle cycles first; valid stays high
   // after the beat so back-to-back pairs never drop it within one step
   task automatic send_pair(input logic [SMP_W-1:0] sig, input logic [SMP_W-1:0] ret,
                            input logic last, input logic typed, input corr_type typed_res);
      corr_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.signal_sample  <= sig;
      req_bus.return_sample  <= ret;
      req_bus.last_of_series <= last;
      do
         @(posedge clock);
      while (!req_bus.ready);
      predicted = step_correlation(sig, ret, last);
      pending_corr = {pending_corr, (typed ? typed_res : predicted)};
   endtask

   // holds the sender off until every outstanding result beat has been taken
   task automatic wait_for_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_corr.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one window length write, only ever issued while the block is idle
   task automatic write_window(input logic [WIN_W-1:0] value);
      @(negedge clock);
      csr_bus.valid         <= 1'b1;
      csr_bus.window_length <= value;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      window_reg = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // receiver back-pressure, low from time zero, then redrawn every cycle
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // result beats against the oldest expectation, field by field
   always @(posedge clock) begin : check_results
      corr_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_corr.size() == 0) begin
            $display("%0t unexpected result beat: rank_correlation %0d correlation_valid %0b",
                     $time, $signed(rsp_bus.rank_correlation), rsp_bus.correlation_valid);
            mismatch_count++;
         end else begin
            want = pending_corr.pop_front();
            if (rsp_bus.rank_correlation !== want.rho) begin
               $display("%0t rank_correlation: expected %0d actual %0d", $time,
                        $signed(want.rho), $signed(rsp_bus.rank_correlation));
               mismatch_count++;
            end
            if (rsp_bus.correlation_valid !== want.ok) begin
               $display("%0t correlation_valid: expected %0b actual %0b", $time,
                        want.ok, rsp_bus.correlation_valid);
               mismatch_count++;
            end
         end
      end
   end

   // hang detection: any beat on any channel resets the count
   always @(posedge clock) begin : watchdog
      if (reset)
         idle_cycles <= 0;
      else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
               (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      logic [SMP_W-1:0] sig;
      logic [SMP_W-1:0] ret;
      logic             last;
      logic [WIN_W-1:0] win_value;
      corr_type         typed_res;
      int unsigned      shape;

      // every block input known from time zero
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.signal_sample  = '0;
      req_bus.return_sample  = '0;
      req_bus.last_of_series = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.window_length  = '0;
      send_idle_pct          = 0;
      recv_stall_pct         = 0;
      fill_pos               = 0;
      pairs_held             = 0;
      window_reg             = WIN_W'(WIN_MAX);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset window, no flow-control gaps
      for (int r = 0; r < $size(DIRECTED_ROWS); r++) begin
         typed_res.rho = DIRECTED_ROWS[r].rho;
         typed_res.ok  = DIRECTED_ROWS[r].ok;
         send_pair(DIRECTED_ROWS[r].sig, DIRECTED_ROWS[r].ret, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].typed, typed_res);
      end

      typed_res = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         // drain fully before touching the register; history carries over
         wait_for_results();
         if (PHASE_WINDOW[p] == RANDOM_WINDOW)
            win_value = WIN_W'($urandom_range(5, WIN_MAX - 1));
         else
            win_value = WIN_W'(PHASE_WINDOW[p]);
         write_window(win_value);
         send_idle_pct  = PHASE_SEND_IDLE[p];
         recv_stall_pct = PHASE_RECV_STALL[p];

         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            sig = draw_sample();
            // return either unrelated, in step or mirrored, so rho spans its range
            shape = $urandom_range(0, 9);
            if (shape < 4)
               ret = draw_sample();
            else if (shape < 7)
               ret = sig;
            else
               ret = ~sig;
            last = ($urandom_range(0, 99) < PHASE_LAST_PCT[p]);
            send_pair(sig, ret, last, 1'b0, typed_res);
         end
      end

      wait_for_results();
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_corr.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rsrc_pkg.sv
rtl/core/rsrc_req_if.sv
rtl/core/rsrc_rsp_if.sv
rtl/core/rsrc_csr_if.sv
rtl/core/rsrc_divider.sv
rtl/core/rolling_spearman_rank_correlation.sv
test/rolling_spearman_rank_correlation_test.sv
